// ----- rtl/core/uart_rb_pkg.sv -----
package uart_rb_pkg;

    // Operation carried in each input beat
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_RX    = 2'd2
    } func_t;

    // Register map
    typedef enum logic [2:0] {
        REG_CTRL       = 3'd0,
        REG_STATUS     = 3'd1,
        REG_TX         = 3'd2,
        REG_RX         = 3'd3,
        REG_BAUD       = 3'd4,
        REG_INT_EN     = 3'd5,
        REG_INT_STATUS = 3'd6,
        REG_UNMAPPED   = 3'd7
    } reg_idx_t;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INT_EN_W = 2;

    // Bit positions
    localparam int unsigned CTRL_TX_EN_BIT   = 0;
    localparam int unsigned CTRL_RX_EN_BIT   = 1;
    localparam int unsigned STAT_TX_RDY_BIT  = 0;
    localparam int unsigned STAT_RX_RDY_BIT  = 1;
    localparam int unsigned INT_RX_PEND_BIT  = 1;

    localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_0001;

    // Stream payload widths
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned S_TUSER_W = 5;
    localparam int unsigned M_TDATA_W = 48;

    typedef struct packed {
        func_t             func;
        reg_idx_t          reg_index;
        logic [DATA_W-1:0] write_value;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              irq;
    } result_t;

endpackage

// ----- rtl/core/uart_register_block.sv -----
// An accepted beat passes the input register, then the result register, to m_axis.
// Throughput: one beat per cycle unless m_axis_tready stalls the result register; the register
// update is combinational logic between the input register and the result register.
// Reset: synchronous, active low; clears the register file, except that status resets to tx
// ready, and both stream stages come up empty; the stage data registers are not reset.
module uart_register_block (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] write_value, [39:32] rx_byte
    input  logic [uart_rb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] func, [4:2] reg_index
    input  logic [uart_rb_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] read_data, [32] tx_valid, [40:33] tx_byte, [41] irq, [47:42] zero
    output logic [uart_rb_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int unsigned RES_W = $bits(uart_rb_pkg::result_t);

    logic                 in_valid_reg;
    uart_rb_pkg::item_t   in_item_reg;
    logic                 out_valid_reg;
    uart_rb_pkg::result_t out_res_reg;
    uart_rb_pkg::result_t res;
    logic                 exec;

    // Process the held beat whenever the result register is free or draining
    assign exec          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || exec;

    uart_rb_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (exec),
        .item    (in_item_reg),
        .result  (res)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.func        <= uart_rb_pkg::func_t'(s_axis_tuser[1:0]);
            in_item_reg.reg_index   <= uart_rb_pkg::reg_idx_t'(s_axis_tuser[4:2]);
            in_item_reg.write_value <= s_axis_tdata[31:0];
            in_item_reg.rx_byte     <= s_axis_tdata[39:32];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(uart_rb_pkg::M_TDATA_W-RES_W){1'b0}},
                            out_res_reg.irq,
                            out_res_reg.tx_byte,
                            out_res_reg.tx_valid,
                            out_res_reg.read_data};

endmodule

// ----- rtl/core/uart_rb_regfile.sv -----
module uart_rb_regfile (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                exec,
    input  uart_rb_pkg::item_t  item,
    output uart_rb_pkg::result_t result
);

    logic [uart_rb_pkg::DATA_W-1:0]   ctrl_reg, ctrl_next;
    logic [uart_rb_pkg::DATA_W-1:0]   status_reg, status_next;
    logic [uart_rb_pkg::BYTE_W-1:0]   tx_data_reg, tx_data_next;
    logic [uart_rb_pkg::BYTE_W-1:0]   rx_data_reg, rx_data_next;
    logic [uart_rb_pkg::DATA_W-1:0]   baud_reg, baud_next;
    logic [uart_rb_pkg::INT_EN_W-1:0] int_en_reg, int_en_next;
    // only the receive pending bit of interrupt status can ever be set
    logic                             rx_pend_reg, rx_pend_next;

    logic [uart_rb_pkg::DATA_W-1:0] int_status_view;

    always_comb begin
        int_status_view = '0;
        int_status_view[uart_rb_pkg::INT_RX_PEND_BIT] = rx_pend_reg;
    end

    // Decode the beat and work out the next register values and the result
    always_comb begin
        ctrl_next    = ctrl_reg;
        status_next  = status_reg;
        tx_data_next = tx_data_reg;
        rx_data_next = rx_data_reg;
        baud_next    = baud_reg;
        int_en_next  = int_en_reg;
        rx_pend_next = rx_pend_reg;

        result.read_data = '0;
        result.tx_valid  = 1'b0;
        result.tx_byte   = '0;

        if (exec) begin
            case (item.func)
                uart_rb_pkg::FUNC_WRITE: begin
                    unique case (item.reg_index)
                        uart_rb_pkg::REG_CTRL:   ctrl_next = item.write_value;
                        uart_rb_pkg::REG_STATUS: status_next = item.write_value;
                        uart_rb_pkg::REG_TX: begin
                            if (ctrl_reg[uart_rb_pkg::CTRL_TX_EN_BIT]) begin
                                tx_data_next = item.write_value[uart_rb_pkg::BYTE_W-1:0];
                                result.tx_valid = 1'b1;
                                result.tx_byte  = item.write_value[uart_rb_pkg::BYTE_W-1:0];
                                status_next[uart_rb_pkg::STAT_TX_RDY_BIT] = 1'b1;
                            end
                        end
                        uart_rb_pkg::REG_BAUD: baud_next = item.write_value;
                        uart_rb_pkg::REG_INT_EN:
                            int_en_next = item.write_value[uart_rb_pkg::INT_EN_W-1:0];
                        uart_rb_pkg::REG_INT_STATUS: begin
                            // write one to clear
                            if (item.write_value[uart_rb_pkg::INT_RX_PEND_BIT]) begin
                                rx_pend_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                uart_rb_pkg::FUNC_READ: begin
                    unique case (item.reg_index)
                        uart_rb_pkg::REG_CTRL:   result.read_data = ctrl_reg;
                        uart_rb_pkg::REG_STATUS: result.read_data = status_reg;
                        uart_rb_pkg::REG_TX:
                            result.read_data = {{(uart_rb_pkg::DATA_W-uart_rb_pkg::BYTE_W){1'b0}},
                                                tx_data_reg};
                        uart_rb_pkg::REG_RX: begin
                            result.read_data = {{(uart_rb_pkg::DATA_W-uart_rb_pkg::BYTE_W){1'b0}},
                                                rx_data_reg};
                            status_next[uart_rb_pkg::STAT_RX_RDY_BIT] = 1'b0;
                        end
                        uart_rb_pkg::REG_BAUD: result.read_data = baud_reg;
                        uart_rb_pkg::REG_INT_EN:
                            result.read_data = {{(uart_rb_pkg::DATA_W-uart_rb_pkg::INT_EN_W){1'b0}},
                                                int_en_reg};
                        uart_rb_pkg::REG_INT_STATUS: result.read_data = int_status_view;
                        default: result.read_data = '0;
                    endcase
                end
                uart_rb_pkg::FUNC_RX: begin
                    // store only when enabled and the buffer is empty, else drop
                    if (ctrl_reg[uart_rb_pkg::CTRL_RX_EN_BIT] &&
                        !status_reg[uart_rb_pkg::STAT_RX_RDY_BIT]) begin
                        rx_data_next = item.rx_byte;
                        status_next[uart_rb_pkg::STAT_RX_RDY_BIT] = 1'b1;
                        rx_pend_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // interrupt line as seen after this beat
        result.irq = rx_pend_next & int_en_next[uart_rb_pkg::INT_RX_PEND_BIT];
    end

    // Hold register state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg    <= '0;
            status_reg  <= uart_rb_pkg::STATUS_RESET;
            tx_data_reg <= '0;
            rx_data_reg <= '0;
            baud_reg    <= '0;
            int_en_reg  <= '0;
            rx_pend_reg <= 1'b0;
        end else begin
            ctrl_reg    <= ctrl_next;
            status_reg  <= status_next;
            tx_data_reg <= tx_data_next;
            rx_data_reg <= rx_data_next;
            baud_reg    <= baud_next;
            int_en_reg  <= int_en_next;
            rx_pend_reg <= rx_pend_next;
        end
    end

endmodule

// ----- verif/uart_register_block_test.sv -----
module uart_register_block_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Spare func code: the block must treat it as no operation
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int unsigned LIMIT_CYCLES = 250000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_BEATS = 1130;
    localparam int unsigned CALM_BEATS = 150;
    localparam int unsigned CHUNK_BEATS = 50;

    // Register-file predictor and store of expected result beats
    class uart_reg_scoreboard;
        logic [uart_rb_pkg::DATA_W-1:0]   ctrl_q;
        logic [uart_rb_pkg::DATA_W-1:0]   status_q;
        logic [uart_rb_pkg::BYTE_W-1:0]   tx_q;
        logic [uart_rb_pkg::BYTE_W-1:0]   rx_q;
        logic [uart_rb_pkg::DATA_W-1:0]   baud_q;
        logic [uart_rb_pkg::INT_EN_W-1:0] int_en_q;
        logic [uart_rb_pkg::DATA_W-1:0]   int_stat_q;
        uart_rb_pkg::result_t             pending_q[$];
        int                               mismatches;
        int                               results_seen;
        int                               writes_seen;
        int                               reads_seen;
        int                               rx_offered;
        int                               rx_captured;
        int                               tx_sent;
        int                               irq_high;

        function new();
            ctrl_q       = '0;
            status_q     = uart_rb_pkg::STATUS_RESET;
            tx_q         = '0;
            rx_q         = '0;
            baud_q       = '0;
            int_en_q     = '0;
            int_stat_q   = '0;
            mismatches   = 0;
            results_seen = 0;
            writes_seen  = 0;
            reads_seen   = 0;
            rx_offered   = 0;
            rx_captured  = 0;
            tx_sent      = 0;
            irq_high     = 0;
        endfunction

        // Apply one accepted beat to the register file and queue its result
        function void note_item(logic [1:0] func, uart_rb_pkg::reg_idx_t idx,
                                logic [uart_rb_pkg::DATA_W-1:0] wval,
                                logic [uart_rb_pkg::BYTE_W-1:0] rxb);
            uart_rb_pkg::result_t want;
            want = '0;
            case (func)
                uart_rb_pkg::FUNC_WRITE: begin
                    writes_seen++;
                    case (idx)
                        uart_rb_pkg::REG_CTRL:   ctrl_q = wval;
                        uart_rb_pkg::REG_STATUS: status_q = wval;
                        uart_rb_pkg::REG_TX: begin
                            if (ctrl_q[uart_rb_pkg::CTRL_TX_EN_BIT]) begin
                                tx_q = wval[uart_rb_pkg::BYTE_W-1:0];
                                want.tx_valid = 1'b1;
                                want.tx_byte = tx_q;
                                status_q[uart_rb_pkg::STAT_TX_RDY_BIT] = 1'b1;
                                tx_sent++;
                            end
                        end
                        uart_rb_pkg::REG_BAUD:       baud_q = wval;
                        uart_rb_pkg::REG_INT_EN:
                            int_en_q = wval[uart_rb_pkg::INT_EN_W-1:0];
                        uart_rb_pkg::REG_INT_STATUS: int_stat_q = int_stat_q & ~wval;
                        default: ;
                    endcase
                end
                uart_rb_pkg::FUNC_READ: begin
                    reads_seen++;
                    case (idx)
                        uart_rb_pkg::REG_CTRL:   want.read_data = ctrl_q;
                        uart_rb_pkg::REG_STATUS: want.read_data = status_q;
                        uart_rb_pkg::REG_TX:
                            want.read_data =
                                {{(uart_rb_pkg::DATA_W-uart_rb_pkg::BYTE_W){1'b0}}, tx_q};
                        uart_rb_pkg::REG_RX: begin
                            status_q[uart_rb_pkg::STAT_RX_RDY_BIT] = 1'b0;
                            want.read_data =
                                {{(uart_rb_pkg::DATA_W-uart_rb_pkg::BYTE_W){1'b0}}, rx_q};
                        end
                        uart_rb_pkg::REG_BAUD: want.read_data = baud_q;
                        uart_rb_pkg::REG_INT_EN:
                            want.read_data =
                                {{(uart_rb_pkg::DATA_W-uart_rb_pkg::INT_EN_W){1'b0}}, int_en_q};
                        uart_rb_pkg::REG_INT_STATUS: want.read_data = int_stat_q;
                        default: want.read_data = '0;
                    endcase
                end
                uart_rb_pkg::FUNC_RX: begin
                    rx_offered++;
                    if (ctrl_q[uart_rb_pkg::CTRL_RX_EN_BIT] &&
                        !status_q[uart_rb_pkg::STAT_RX_RDY_BIT]) begin
                        rx_q = rxb;
                        status_q[uart_rb_pkg::STAT_RX_RDY_BIT] = 1'b1;
                        int_stat_q[uart_rb_pkg::INT_RX_PEND_BIT] = 1'b1;
                        rx_captured++;
                    end
                end
                default: ;
            endcase
            want.irq = |(int_stat_q[uart_rb_pkg::INT_EN_W-1:0] & int_en_q);
            if (want.irq) irq_high++;
            pending_q.push_back(want);
        endfunction

        // Compare a result beat with the oldest expectation
        function void check_result(uart_rb_pkg::result_t got);
            uart_rb_pkg::result_t want;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result beat %0d arrived with nothing expected: ",
                              "rd=%h txv=%b txb=%h irq=%b"},
                             results_seen, got.read_data, got.tx_valid, got.tx_byte, got.irq);
                return;
            end
            want = pending_q.pop_front();
            if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid ||
                got.tx_byte !== want.tx_byte || got.irq !== want.irq) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result beat %0d mismatch: exp rd=%h txv=%b txb=%h irq=%b, ",
                              "got rd=%h txv=%b txb=%h irq=%b"},
                             results_seen, want.read_data, want.tx_valid, want.tx_byte, want.irq,
                             got.read_data, got.tx_valid, got.tx_byte, got.irq);
            end
        endfunction
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [uart_rb_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [uart_rb_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [uart_rb_pkg::M_TDATA_W-1:0] m_axis_tdata;

    uart_reg_scoreboard sb = new();
    int unsigned cycle_count = 0;
    bit src_idle_on = 1'b0;
    bit sink_idle_on = 1'b0;
    bit hold_req = 1'b0;

    uart_register_block u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abandon the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Record accepted beats on both sides; results first, they belong to older inputs
    always @(posedge aclk) begin
        uart_rb_pkg::result_t got;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.read_data = m_axis_tdata[31:0];
                got.tx_valid  = m_axis_tdata[32];
                got.tx_byte   = m_axis_tdata[40:33];
                got.irq       = m_axis_tdata[41];
                sb.check_result(got);
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(s_axis_tuser[1:0], uart_rb_pkg::reg_idx_t'(s_axis_tuser[4:2]),
                             s_axis_tdata[31:0], s_axis_tdata[39:32]);
        end
    end

    // Result-side ready: random stalls, and one long hold-off on request
    initial begin
        int unsigned held;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
                hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Offer one beat and hold it until it is taken
    task automatic send_beat(logic [1:0] func, uart_rb_pkg::reg_idx_t idx,
                             logic [uart_rb_pkg::DATA_W-1:0] wval,
                             logic [uart_rb_pkg::BYTE_W-1:0] rxb);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {idx, func};
        s_axis_tdata  <= {rxb, wval};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    function automatic logic [uart_rb_pkg::DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // One random beat, or a short receive-and-service sequence; returns beats sent
    task automatic send_random(output int sent);
        int unsigned pick;
        logic [uart_rb_pkg::DATA_W-1:0] w;
        uart_rb_pkg::reg_idx_t idx;
        pick = $urandom_range(0, 99);
        idx = uart_rb_pkg::reg_idx_t'($urandom_range(0, 7));
        w = rand_word();
        sent = 1;
        if (pick < 10) begin
            // Byte arrives, software polls status, drains rx and acknowledges
            send_beat(uart_rb_pkg::FUNC_RX, idx, rand_word(), 8'($urandom));
            send_beat(uart_rb_pkg::FUNC_READ, uart_rb_pkg::REG_STATUS, rand_word(),
                      8'($urandom));
            send_beat(uart_rb_pkg::FUNC_READ, uart_rb_pkg::REG_RX, rand_word(), 8'($urandom));
            send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_INT_STATUS,
                      $urandom_range(0, 1) ? 32'h2 : w, 8'($urandom));
            sent = 4;
        end else if (pick < 45) begin
            if (idx == uart_rb_pkg::REG_CTRL && $urandom_range(0, 3) != 0) w[1:0] = 2'b11;
            if (idx == uart_rb_pkg::REG_STATUS && $urandom_range(0, 1) != 0)
                w[uart_rb_pkg::STAT_RX_RDY_BIT] = 1'b0;
            send_beat(uart_rb_pkg::FUNC_WRITE, idx, w, 8'($urandom));
        end else if (pick < 75) begin
            if ($urandom_range(0, 2) == 0) idx = uart_rb_pkg::REG_RX;
            send_beat(uart_rb_pkg::FUNC_READ, idx, w, 8'($urandom));
        end else if (pick < 95) begin
            send_beat(uart_rb_pkg::FUNC_RX, idx, w, 8'($urandom));
        end else begin
            send_beat(FUNC_NONE, idx, w, 8'($urandom));
        end
    endtask

    initial begin
        int sent;
        int chunk;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values of every register, the unmapped one included
        for (int i = 0; i < 8; i++)
            send_beat(uart_rb_pkg::FUNC_READ, uart_rb_pkg::reg_idx_t'(i), '0, '0);
        // Enable both directions, send all-ones, receive all-ones, overrun drops
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_CTRL, 32'hFFFF_FFFF, 8'h00);
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_TX, 32'hFFFF_FFFF, 8'h00);
        send_beat(uart_rb_pkg::FUNC_RX, uart_rb_pkg::REG_CTRL, 32'h0, 8'hFF);
        send_beat(uart_rb_pkg::FUNC_RX, uart_rb_pkg::REG_UNMAPPED, 32'hFFFF_FFFF, 8'h00);
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_INT_EN, 32'hFFFF_FFFF, 8'hFF);
        send_beat(uart_rb_pkg::FUNC_READ, uart_rb_pkg::REG_RX, 32'h0, 8'h00);
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_INT_STATUS, 32'hFFFF_FFFF, 8'h00);
        // Full-width status and baud writes, ignored rx and unmapped writes
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_STATUS, 32'hFFFF_FFFF, 8'h00);
        send_beat(uart_rb_pkg::FUNC_READ, uart_rb_pkg::REG_STATUS, 32'h0, 8'h00);
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_BAUD, 32'hFFFF_FFFF, 8'h00);
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_RX, 32'hFFFF_FFFF, 8'h00);
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_UNMAPPED, 32'hFFFF_FFFF, 8'h00);
        send_beat(FUNC_NONE, uart_rb_pkg::REG_UNMAPPED, 32'hFFFF_FFFF, 8'hFF);
        // Everything disabled: transmit and receive both fall away
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_STATUS, 32'h0, 8'h00);
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_CTRL, 32'h0, 8'h00);
        send_beat(uart_rb_pkg::FUNC_WRITE, uart_rb_pkg::REG_TX, 32'h0000_00A5, 8'h00);
        send_beat(uart_rb_pkg::FUNC_RX, uart_rb_pkg::REG_CTRL, 32'h0, 8'h5A);
        send_beat(uart_rb_pkg::FUNC_READ, uart_rb_pkg::REG_STATUS, 32'h0, 8'h00);

        // Random traffic in chunks, idling switched per chunk
        sent = 0;
        chunk = 0;
        while (sent < RANDOM_BEATS - CALM_BEATS) begin
            int n;
            int one;
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            if (chunk == 3) begin
                // Sender keeps offering while the result side is held off
                src_idle_on = 1'b0;
                hold_req = 1'b1;
            end
            n = 0;
            while (n < CHUNK_BEATS) begin
                send_random(one);
                n += one;
            end
            sent += n;
            chunk++;
        end

        // Closing stretch at full rate on both sides
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (sent < RANDOM_BEATS) begin
            int one;
            send_random(one);
            sent += one;
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline depth
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Covered %0d writes, %0d reads, %0d bytes offered on rx (%0d captured).",
                 sb.writes_seen, sb.reads_seen, sb.rx_offered, sb.rx_captured);
        $display("Bytes sent on tx: %0d; results with irq high: %0d; result beats checked: %0d.",
                 sb.tx_sent, sb.irq_high, sb.results_seen);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- uart_register_block.f -----
rtl/core/uart_rb_pkg.sv
rtl/core/uart_rb_regfile.sv
rtl/core/uart_register_block.sv
verif/uart_register_block_test.sv
